// ===== rtl/binaural_crossover_fir_spatializer_defines.svh =====
// Assertion macros for the binaural spatializer checker
`ifndef BINAURAL_CROSSOVER_FIR_SPATIALIZER_DEFINES_SVH
`define BINAURAL_CROSSOVER_FIR_SPATIALIZER_DEFINES_SVH

// Check a property on the rising clock edge while out of reset
`define BCFS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on the rising clock edge, reset cycles included
`define BCFS_ASSERT_ANY(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/bcfs_pkg.sv =====
// Shared types and constants of the binaural crossover FIR spatializer
`default_nettype none
package bcfs_pkg;

    localparam int TAPS_DEFAULT = 200;

    // Item operation codes
    localparam logic [1:0] OP_SAMPLE    = 2'd0;
    localparam logic [1:0] OP_TAP_LEFT  = 2'd1;
    localparam logic [1:0] OP_TAP_RIGHT = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_LOW_B0      = 3'd0;
    localparam logic [2:0] REG_HIGH_B0     = 3'd1;
    localparam logic [2:0] REG_FEEDBACK_A1 = 3'd2;
    localparam logic [2:0] REG_FEEDBACK_A2 = 3'd3;
    localparam logic [2:0] REG_WET_GAIN    = 3'd4;
    localparam logic [2:0] REG_STEREO_IN   = 3'd5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [16:0] WET_FULL = 17'd65536;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] sample_left;
        logic signed [15:0] sample_right;
        logic [7:0]         tap_index;
        logic signed [15:0] tap_value;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] out_left;
        logic signed [15:0] out_right;
    } out_item_t;

endpackage
`default_nettype wire

// ===== rtl/binaural_crossover_fir_spatializer.sv =====
// An audio word passes through S_BIQ, S_BRND, S_CONV, S_CRND, S_MIX0,
// S_MIX1 and S_OUT before m_valid rises, the two-lane MAC walking one tap
// per cycle in S_CONV; s_ready stays low until S_OUT hands the result to a free
// output register. Tap writes and unused ops are taken without leaving S_IDLE.
// Reset: synchronous active-low; then S_CLEAR zeroes the ring and loads a unit
// impulse into both impulse-response memories while s_ready stays low.
`default_nettype none
module binaural_crossover_fir_spatializer
    import bcfs_pkg::*;
#(
    parameter int TAPS = TAPS_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CW    = $clog2(TAPS + 1);
    localparam int ACC_W = 52;
    localparam int SUM_W = 26;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_BIQ   = 4'd2;
    localparam logic [3:0] S_BRND  = 4'd3;
    localparam logic [3:0] S_CONV  = 4'd4;
    localparam logic [3:0] S_CRND  = 4'd5;
    localparam logic [3:0] S_MIX0  = 4'd6;
    localparam logic [3:0] S_MIX1  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    localparam logic [1:0] MAC_HOLD = 2'd0;
    localparam logic [1:0] MAC_LOAD = 2'd1;
    localparam logic [1:0] MAC_ADD  = 2'd2;
    localparam logic [1:0] MAC_SUB  = 2'd3;

    function automatic logic signed [23:0] sat24(input logic signed [ACC_W-1:0] v);
        if (v[ACC_W-1:23] == '0 || v[ACC_W-1:23] == '1) begin
            return v[23:0];
        end
        return v[ACC_W-1] ? 24'sh800000 : 24'sh7fffff;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
        if (v[ACC_W-1:15] == '0 || v[ACC_W-1:15] == '1) begin
            return v[15:0];
        end
        return v[ACC_W-1] ? 16'sh8000 : 16'sh7fff;
    endfunction

    // Configuration registers
    logic signed [23:0] low_b0_reg, high_b0_reg, fb_a1_reg, fb_a2_reg;
    logic [16:0]        wet_reg;
    logic               stereo_reg;

    // Control and datapath registers
    logic [3:0]  state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [2:0]  step_reg, step_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] ridx_reg, ridx_next;
    logic signed [15:0] mono_reg, mono_next;
    logic signed [15:0] d1_reg, d1_next, d2_reg, d2_next;
    logic signed [23:0] yl0_reg, yl0_next, yl1_reg, yl1_next;
    logic signed [23:0] yh0_reg, yh0_next, yh1_reg, yh1_next;
    logic signed [23:0] lo_reg, lo_next;
    logic signed [SUM_W-1:0] suml_reg, suml_next, sumr_reg, sumr_next;
    logic signed [ACC_W-1:0] accl_reg, accl_next, accr_reg, accr_next;
    logic        m_valid_reg, m_valid_next;
    out_item_t   out_reg, out_next;

    // Memories
    logic signed [15:0] ring_mem [TAPS];
    logic signed [15:0] ltap_mem [TAPS];
    logic signed [15:0] rtap_mem [TAPS];
    logic signed [15:0] ring_rd_reg, ltap_rd_reg, rtap_rd_reg;
    logic               ring_we, ltap_we, rtap_we;
    logic [AW-1:0]      ring_waddr, tap_waddr, tap_raddr;
    logic signed [15:0] ring_wdata, tap_wdata;

    // Shared two-lane multiplier
    logic signed [25:0] mac_al, mac_ar;
    logic signed [24:0] mac_bl, mac_br;
    logic signed [50:0] prod_l, prod_r;
    logic [1:0]         mac_op;

    logic               s_fire;
    logic               can_out;
    logic               tap_ok;
    logic [16:0]        wet_c, dry_c;
    logic signed [16:0] stereo_sum;
    logic signed [ACC_W-1:0] rl, rr, bl, bh, ol, orr;
    logic signed [25:0] b0l2, b0h2n;

    assign s_ready = (state_reg == S_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;
    assign can_out = !m_valid_reg || m_ready;
    assign tap_ok  = (32'(s_data.tap_index) < TAPS);

    assign wet_c = (wet_reg > WET_FULL) ? WET_FULL : wet_reg;
    assign dry_c = WET_FULL - wet_c;
    assign stereo_sum = 17'(s_data.sample_left) + 17'(s_data.sample_right);
    assign b0l2  = {{1{low_b0_reg[23]}}, low_b0_reg, 1'b0};
    assign b0h2n = -{{1{high_b0_reg[23]}}, high_b0_reg, 1'b0};

    assign prod_l = mac_al * mac_bl;
    assign prod_r = mac_ar * mac_br;

    // Rounded accumulator views
    assign bl  = (accl_reg + ACC_W'(64'sd2097152)) >>> 22;
    assign bh  = (accr_reg + ACC_W'(64'sd2097152)) >>> 22;
    assign rl  = (accl_reg + ACC_W'(64'sd16384)) >>> 15;
    assign rr  = (accr_reg + ACC_W'(64'sd16384)) >>> 15;
    assign ol  = (accl_reg + ACC_W'(64'sd32768)) >>> 16;
    assign orr = (accr_reg + ACC_W'(64'sd32768)) >>> 16;

    // Sequence the shared multiplier
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        step_next    = step_reg;
        pos_next     = pos_reg;
        ridx_next    = ridx_reg;
        mono_next    = mono_reg;
        d1_next      = d1_reg;
        d2_next      = d2_reg;
        yl0_next     = yl0_reg;
        yl1_next     = yl1_reg;
        yh0_next     = yh0_reg;
        yh1_next     = yh1_reg;
        lo_next      = lo_reg;
        suml_next    = suml_reg;
        sumr_next    = sumr_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        mac_op       = MAC_HOLD;
        mac_al       = '0;
        mac_ar       = '0;
        mac_bl       = '0;
        mac_br       = '0;
        ring_we      = 1'b0;
        ring_waddr   = pos_reg;
        ring_wdata   = '0;
        ltap_we      = 1'b0;
        rtap_we      = 1'b0;
        tap_waddr    = AW'(s_data.tap_index);
        tap_wdata    = s_data.tap_value;
        tap_raddr    = '0;

        case (state_reg)
            S_CLEAR: begin
                ring_we    = 1'b1;
                ring_waddr = cnt_reg[AW-1:0];
                ltap_we    = 1'b1;
                rtap_we    = 1'b1;
                tap_waddr  = cnt_reg[AW-1:0];
                tap_wdata  = (cnt_reg == '0) ? 16'sh7fff : 16'sh0000;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CW'(TAPS - 1)) begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_fire) begin
                    case (s_data.op)
                        OP_SAMPLE: begin
                            mono_next  = stereo_reg ? stereo_sum[16:1] : s_data.sample_left;
                            step_next  = '0;
                            state_next = S_BIQ;
                        end
                        OP_TAP_LEFT:  ltap_we = tap_ok;
                        OP_TAP_RIGHT: rtap_we = tap_ok;
                        default: ;
                    endcase
                end
            end
            S_BIQ: begin
                // Low band in the left lane, high band in the right lane
                step_next = step_reg + 3'd1;
                case (step_reg)
                    3'd0: begin
                        mac_op = MAC_LOAD;
                        mac_al = 26'(low_b0_reg);
                        mac_ar = 26'(high_b0_reg);
                        mac_bl = 25'(mono_reg);
                        mac_br = 25'(mono_reg);
                    end
                    3'd1: begin
                        mac_op = MAC_ADD;
                        mac_al = b0l2;
                        mac_ar = b0h2n;
                        mac_bl = 25'(d1_reg);
                        mac_br = 25'(d1_reg);
                    end
                    3'd2: begin
                        mac_op = MAC_ADD;
                        mac_al = 26'(low_b0_reg);
                        mac_ar = 26'(high_b0_reg);
                        mac_bl = 25'(d2_reg);
                        mac_br = 25'(d2_reg);
                    end
                    3'd3: begin
                        mac_op = MAC_SUB;
                        mac_al = 26'(fb_a1_reg);
                        mac_ar = 26'(fb_a1_reg);
                        mac_bl = 25'(yl0_reg);
                        mac_br = 25'(yh0_reg);
                    end
                    default: begin
                        mac_op     = MAC_SUB;
                        mac_al     = 26'(fb_a2_reg);
                        mac_ar     = 26'(fb_a2_reg);
                        mac_bl     = 25'(yl1_reg);
                        mac_br     = 25'(yh1_reg);
                        state_next = S_BRND;
                    end
                endcase
            end
            S_BRND: begin
                // Round the biquads, shift histories, push the high band
                lo_next    = sat24(bl);
                yl0_next   = sat24(bl);
                yl1_next   = yl0_reg;
                yh0_next   = sat24(bh);
                yh1_next   = yh0_reg;
                d1_next    = mono_reg;
                d2_next    = d1_reg;
                ring_we    = 1'b1;
                ring_wdata = sat16(ACC_W'(sat24(bh)));
                ridx_next  = pos_reg;
                cnt_next   = '0;
                state_next = S_CONV;
            end
            S_CONV: begin
                // Issue tap k reads, accumulate the words read last cycle
                tap_raddr = (cnt_reg < CW'(TAPS)) ? cnt_reg[AW-1:0] : '0;
                ridx_next = (ridx_reg == '0) ? AW'(TAPS - 1) : ridx_reg - 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg != '0) begin
                    mac_op = (cnt_reg == CW'(1)) ? MAC_LOAD : MAC_ADD;
                    mac_al = 26'(ltap_rd_reg);
                    mac_ar = 26'(rtap_rd_reg);
                    mac_bl = 25'(ring_rd_reg);
                    mac_br = 25'(ring_rd_reg);
                end
                if (cnt_reg == CW'(TAPS)) begin
                    state_next = S_CRND;
                end
            end
            S_CRND: begin
                suml_next  = SUM_W'(ACC_W'(lo_reg) + rl);
                sumr_next  = SUM_W'(ACC_W'(lo_reg) + rr);
                pos_next   = (pos_reg == AW'(TAPS - 1)) ? '0 : pos_reg + 1'b1;
                state_next = S_MIX0;
            end
            S_MIX0: begin
                mac_op     = MAC_LOAD;
                mac_al     = suml_reg;
                mac_ar     = sumr_reg;
                mac_bl     = $signed({8'b0, wet_c});
                mac_br     = $signed({8'b0, wet_c});
                state_next = S_MIX1;
            end
            S_MIX1: begin
                mac_op     = MAC_ADD;
                mac_al     = 26'(mono_reg);
                mac_ar     = 26'(mono_reg);
                mac_bl     = $signed({8'b0, dry_c});
                mac_br     = $signed({8'b0, dry_c});
                state_next = S_OUT;
            end
            S_OUT: begin
                // Hold until the output register is free
                if (can_out) begin
                    out_next.out_left  = sat16(ol);
                    out_next.out_right = sat16(orr);
                    m_valid_next       = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Advance the accumulators
    always_comb begin
        case (mac_op)
            MAC_LOAD: begin
                accl_next = ACC_W'(prod_l);
                accr_next = ACC_W'(prod_r);
            end
            MAC_ADD: begin
                accl_next = accl_reg + ACC_W'(prod_l);
                accr_next = accr_reg + ACC_W'(prod_r);
            end
            MAC_SUB: begin
                accl_next = accl_reg - ACC_W'(prod_l);
                accr_next = accr_reg - ACC_W'(prod_r);
            end
            default: begin
                accl_next = accl_reg;
                accr_next = accr_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            cnt_reg     <= '0;
            step_reg    <= '0;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
            d1_reg      <= '0;
            d2_reg      <= '0;
            yl0_reg     <= '0;
            yl1_reg     <= '0;
            yh0_reg     <= '0;
            yh1_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            step_reg    <= step_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
            d1_reg      <= d1_next;
            d2_reg      <= d2_next;
            yl0_reg     <= yl0_next;
            yl1_reg     <= yl1_next;
            yh0_reg     <= yh0_next;
            yh1_reg     <= yh1_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        ridx_reg <= ridx_next;
        mono_reg <= mono_next;
        lo_reg   <= lo_next;
        suml_reg <= suml_next;
        sumr_reg <= sumr_next;
        accl_reg <= accl_next;
        accr_reg <= accr_next;
        out_reg  <= out_next;
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_b0_reg  <= '0;
            high_b0_reg <= '0;
            fb_a1_reg   <= '0;
            fb_a2_reg   <= '0;
            wet_reg     <= WET_FULL;
            stereo_reg  <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_LOW_B0:      low_b0_reg  <= cfg_data;
                REG_HIGH_B0:     high_b0_reg <= cfg_data;
                REG_FEEDBACK_A1: fb_a1_reg   <= cfg_data;
                REG_FEEDBACK_A2: fb_a2_reg   <= cfg_data;
                REG_WET_GAIN:    wet_reg     <= cfg_data[16:0];
                REG_STEREO_IN:   stereo_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // High-band ring
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[ring_waddr] <= ring_wdata;
        end
        ring_rd_reg <= ring_mem[ridx_reg];
    end

    // Left impulse response
    always_ff @(posedge aclk) begin
        if (ltap_we) begin
            ltap_mem[tap_waddr] <= tap_wdata;
        end
        ltap_rd_reg <= ltap_mem[tap_raddr];
    end

    // Right impulse response
    always_ff @(posedge aclk) begin
        if (rtap_we) begin
            rtap_mem[tap_waddr] <= tap_wdata;
        end
        rtap_rd_reg <= rtap_mem[tap_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/bcfs_checker.sv =====
// Port-level checker for the binaural spatializer and its bind
`default_nettype none
`include "binaural_crossover_fir_spatializer_defines.svh"
module bcfs_checker
    import bcfs_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire in_item_t  s_data,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data
);

    `BCFS_ASSERT(a_sample_busy, (s_valid && s_ready && s_data.op == OP_SAMPLE) |=> !s_ready, "audio word did not start processing")
    `BCFS_ASSERT(a_tap_quick, (s_valid && s_ready && s_data.op != OP_SAMPLE) |=> s_ready, "tap word held the input")
    `BCFS_ASSERT_ANY(a_reset_quiet, !aresetn |=> !m_valid, "result word shown after reset")
    `BCFS_ASSERT(a_out_hold, (m_valid && !m_ready) |=> (m_valid && $stable(m_data)), "stalled result word changed")

endmodule

bind binaural_crossover_fir_spatializer bcfs_checker u_bcfs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire

// ===== tb/binaural_crossover_fir_spatializer_tb.sv =====
// Self-checking testbench for the binaural crossover FIR spatializer
`timescale 1ns / 100ps
`default_nettype none
module binaural_crossover_fir_spatializer_tb;
    import bcfs_pkg::*;

    localparam int NTAPS = TAPS_DEFAULT;
    localparam int DRAIN = NTAPS + 40;
    localparam int ITEM_W = $bits(in_item_t);
    localparam logic [1:0] OP_SPARE = 2'd3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    binaural_crossover_fir_spatializer dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 aclk = ~aclk;

    // Spatializer state mirrored in the checker
    longint c_low_b0, c_high_b0, c_a1, c_a2;
    logic [16:0] c_wet;
    logic c_stereo;
    longint x_d1, x_d2;
    longint low_y[2], high_y[2];
    longint ring[NTAPS];
    int ring_pos;
    longint ir_left[NTAPS], ir_right[NTAPS];

    in_item_t item_q[$];
    out_item_t expect_q[$];
    int errors = 0;
    int rx_count = 0;
    logic taken = 1'b0;
    int hold_left = 0;
    logic hold_done = 1'b0;

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, int w);
        longint hi;
        hi = (longint'(1) << (w - 1)) - 1;
        return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    // Append a word to the pending queue
    task automatic queue_word(input in_item_t it);
        item_q.insert(item_q.size(), it);
    endtask

    // One biquad section; the input history is shared between the two bands
    function automatic longint biquad_step(longint x, longint b0, longint b1, ref longint yd[2]);
        longint acc, y;
        acc = b0 * x + b1 * x_d1 + b0 * x_d2 - c_a1 * yd[0] - c_a2 * yd[1];
        y = clip(round_shift(acc, 22), 24);
        yd[1] = yd[0];
        yd[0] = y;
        return y;
    endfunction

    // Advance the mirrored state by one word; returns 1 when it yields a result
    function automatic bit spatialize(input in_item_t it, output out_item_t res);
        longint mono, lo, hi, accl, accr, wet, suml, sumr;
        int k, j;
        res = '0;
        if (it.op == OP_TAP_LEFT || it.op == OP_TAP_RIGHT) begin
            if (it.tap_index < NTAPS) begin
                if (it.op == OP_TAP_LEFT) ir_left[it.tap_index] = it.tap_value;
                else ir_right[it.tap_index] = it.tap_value;
            end
            return 1'b0;
        end
        if (it.op != OP_SAMPLE) return 1'b0;
        mono = it.sample_left;
        if (c_stereo) mono = (mono + longint'(it.sample_right)) >>> 1;
        lo = biquad_step(mono, c_low_b0, 2 * c_low_b0, low_y);
        hi = biquad_step(mono, c_high_b0, -2 * c_high_b0, high_y);
        x_d2 = x_d1;
        x_d1 = mono;
        ring[ring_pos] = clip(hi, 16);
        accl = 0;
        accr = 0;
        for (k = 0; k < NTAPS; k++) begin
            j = (ring_pos + NTAPS - k) % NTAPS;
            accl += ir_left[k] * ring[j];
            accr += ir_right[k] * ring[j];
        end
        ring_pos = (ring_pos + 1) % NTAPS;
        accl = round_shift(accl, 15);
        accr = round_shift(accr, 15);
        wet = c_wet > WET_FULL ? 65536 : longint'(c_wet);
        suml = wet * (lo + accl) + (65536 - wet) * mono;
        sumr = wet * (lo + accr) + (65536 - wet) * mono;
        res.out_left = 16'(clip(round_shift(suml, 16), 16));
        res.out_right = 16'(clip(round_shift(sumr, 16), 16));
        return 1'b1;
    endfunction

    // Sender: hold the offered word until taken, else maybe launch the next
    always @(negedge aclk) begin
        int idle_pct;
        idle_pct = rx_count < 400 ? 12 : (rx_count < 800 ? 60 : 0);
        if (s_valid && !taken) begin
            s_valid <= 1'b1;
        end else if (aresetn && item_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
            s_valid <= 1'b1;
            s_data <= item_q.pop_front();
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Receiver: random back-pressure plus one long hold-off
    always @(negedge aclk) begin
        int stall_pct;
        stall_pct = rx_count < 400 ? 60 : (rx_count < 800 ? 12 : 0);
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && rx_count == 300) begin
            m_ready <= 1'b0;
            hold_left <= 3000;
            hold_done <= 1'b1;
        end else begin
            m_ready <= aresetn && $urandom_range(0, 99) >= stall_pct;
        end
    end

    // Monitor: predict on accepted inputs, compare accepted results
    always @(posedge aclk) begin
        out_item_t pred, got;
        taken <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            if (spatialize(s_data, pred)) expect_q.insert(expect_q.size(), pred);
        end
        if (aresetn && m_valid && m_ready) begin
            rx_count <= rx_count + 1;
            if (expect_q.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                got = expect_q.pop_front();
                if (m_data.out_left !== got.out_left)
                    report_mismatch($sformatf("out_left %0d, expected %0d",
                        m_data.out_left, got.out_left));
                if (m_data.out_right !== got.out_right)
                    report_mismatch($sformatf("out_right %0d, expected %0d",
                        m_data.out_right, got.out_right));
            end
        end
    end

    // Write all six registers, one per cycle, and mirror them
    task automatic write_regs(input longint lb, hb, a1, a2, input logic [16:0] wet,
                              input logic st);
        logic [CFG_DATA_W-1:0] vals[6];
        logic [CFG_IDX_W-1:0] idxs[6];
        vals = '{lb[23:0], hb[23:0], a1[23:0], a2[23:0], 24'(wet), 24'(st)};
        idxs = '{REG_LOW_B0, REG_HIGH_B0, REG_FEEDBACK_A1, REG_FEEDBACK_A2,
                 REG_WET_GAIN, REG_STEREO_IN};
        for (int i = 0; i < 6; i++) begin
            @(negedge aclk);
            cfg_we <= 1'b1;
            cfg_index <= idxs[i];
            cfg_data <= vals[i];
        end
        c_low_b0 = lb;
        c_high_b0 = hb;
        c_a1 = a1;
        c_a2 = a2;
        c_wet = wet;
        c_stereo = st;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Wait for every pending word and result, then let the block settle
    task automatic drain();
        wait (item_q.size() == 0 && !s_valid && expect_q.size() == 0);
        repeat (DRAIN) @(posedge aclk);
    endtask

    function automatic in_item_t word(logic [1:0] op, int l, int r, int idx, int v);
        in_item_t it;
        it.op = op;
        it.sample_left = 16'(l);
        it.sample_right = 16'(r);
        it.tap_index = 8'(idx);
        it.tap_value = 16'(v);
        return it;
    endfunction

    function automatic in_item_t random_word();
        in_item_t it;
        int pick;
        it = in_item_t'(ITEM_W'({$urandom, $urandom}));
        pick = $urandom_range(0, 99);
        if (pick < 72) it.op = OP_SAMPLE;
        else if (pick < 85) it.op = OP_TAP_LEFT;
        else if (pick < 98) it.op = OP_TAP_RIGHT;
        else it.op = OP_SPARE;
        if (it.op != OP_SAMPLE && $urandom_range(0, 9) != 0)
            it.tap_index = 8'($urandom_range(0, NTAPS - 1));
        if ($urandom_range(0, 3) != 0) it.tap_value = it.tap_value >>> 5;
        return it;
    endfunction

    task automatic queue_random(int n);
        repeat (n) queue_word(random_word());
    endtask

    initial begin
        c_low_b0 = 0; c_high_b0 = 0; c_a1 = 0; c_a2 = 0;
        c_wet = WET_FULL; c_stereo = 1'b0;
        x_d1 = 0; x_d2 = 0;
        low_y = '{0, 0}; high_y = '{0, 0};
        ring_pos = 0;
        for (int k = 0; k < NTAPS; k++) begin
            ring[k] = 0; ir_left[k] = 0; ir_right[k] = 0;
        end
        ir_left[0] = 32767;
        ir_right[0] = 32767;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: pass-through taps, extremes, tap writes and unused op
        queue_word(word(OP_SAMPLE, 32767, 0, 0, 0));
        queue_word(word(OP_SAMPLE, -32768, 0, 0, 0));
        queue_word(word(OP_SAMPLE, 0, -1, 0, 0));
        queue_word(word(OP_TAP_LEFT, 0, 0, 0, -32768));
        queue_word(word(OP_TAP_RIGHT, 0, 0, NTAPS - 1, 32767));
        queue_word(word(OP_TAP_LEFT, 0, 0, NTAPS, 1234));
        queue_word(word(OP_TAP_RIGHT, 0, 0, 255, -1));
        queue_word(word(OP_SPARE, 100, 100, 5, 5));
        queue_word(word(OP_SAMPLE, -32768, 32767, 0, 0));
        queue_word(word(OP_SAMPLE, 1, 1, 0, 0));
        drain();

        // Stereo averaging with full-scale inputs and half wet
        write_regs(0, 0, 0, 0, 17'd32768, 1'b1);
        queue_word(word(OP_SAMPLE, 32767, 32767, 0, 0));
        queue_word(word(OP_SAMPLE, -32768, -32768, 0, 0));
        queue_word(word(OP_SAMPLE, -32768, 32767, 0, 0));
        queue_word(word(OP_SAMPLE, 3, -4, 0, 0));
        queue_word(word(OP_TAP_LEFT, 0, 0, 0, 16384));
        queue_word(word(OP_SAMPLE, 20000, -1000, 0, 0));
        drain();

        // Realistic crossover, stereo input, partly wet
        write_regs(83886, 3357000, -6547000, 2688000, 17'd45000, 1'b1);
        queue_random(400);
        drain();

        // Extremes: largest gains, wet above full
        write_regs(8388607, -8388608, -8388608, 8388607, 17'd131071, 1'b0);
        queue_random(100);
        drain();

        // Fully dry
        write_regs(-8388608, 8388607, 8388607, -8388608, 17'd0, 1'b1);
        queue_random(60);
        drain();

        // Random settings
        for (int p = 0; p < 6; p++) begin
            write_regs(longint'($signed(24'($urandom))), longint'($signed(24'($urandom))),
                       longint'($signed(24'($urandom))), longint'($signed(24'($urandom))),
                       17'($urandom_range(0, 70000)), 1'($urandom));
            queue_random(110);
            drain();
        end

        if (expect_q.size() != 0) report_mismatch("results still expected at end");
        if (errors == 0) begin
            $display("binaural_crossover_fir_spatializer_tb passed");
        end else begin
            $display("binaural_crossover_fir_spatializer_tb failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #40_000_000;
        $display("binaural_crossover_fir_spatializer_tb failed");
        $finish;
    end

endmodule
`default_nettype wire
